/* rtl/core/dbe_pkg.sv */
// Package for the debounced button event block: state codes, config and
// next-state types, and the four transition tables. No dependencies.
package dbe_pkg;

  localparam int unsigned CodeW  = 5;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned HoldW  = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [CodeW-1:0] code_t;

  localparam code_t ST_U   = 5'd0;
  localparam code_t ST_UA  = 5'd1;
  localparam code_t ST_UI  = 5'd2;
  localparam code_t ST_I   = 5'd3;
  localparam code_t ST_IP  = 5'd4;
  localparam code_t ST_IU  = 5'd5;
  localparam code_t ST_IA  = 5'd6;
  localparam code_t ST_IPA = 5'd7;
  localparam code_t ST_IUA = 5'd8;
  localparam code_t ST_A   = 5'd9;
  localparam code_t ST_AP  = 5'd10;
  localparam code_t ST_AU  = 5'd11;
  localparam code_t ST_AI  = 5'd12;
  localparam code_t ST_API = 5'd13;
  localparam code_t ST_AUI = 5'd14;
  localparam code_t ST_S   = 5'd15;
  localparam code_t ST_SP  = 5'd16;
  localparam code_t ST_SI  = 5'd17;
  localparam code_t ST_SPI = 5'd18;
  localparam code_t ST_IS  = 5'd19;
  localparam code_t ST_ISA = 5'd20;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_ACTIVE_LEVEL = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_MS  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SHORT_HOLD   = 2'd2;

  localparam logic             RST_ACTIVE_LEVEL = 1'b1;
  localparam logic [HoldW-1:0] RST_DEBOUNCE_MS  = 16'd50;
  localparam logic [HoldW-1:0] RST_SHORT_HOLD   = 16'd300;

  typedef struct packed {
    logic             active_level;
    logic [HoldW-1:0] debounce_ms;
    logic [HoldW-1:0] short_hold_ms;
  } cfg_t;

  typedef struct packed {
    code_t            code;
    logic             active;
    logic             change_hit;
    logic [TimeW-1:0] change_time;
  } step_t;

  function automatic code_t edge_next(input code_t s, input logic act);
    code_t r;
    r = s;
    if (act) begin
      unique case (s)
        ST_U, ST_UI: r = ST_UA;
        ST_I:        r = ST_IA;
        ST_IP:       r = ST_IPA;
        ST_IU:       r = ST_IUA;
        ST_AU:       r = ST_AUI;
        ST_AI:       r = ST_A;
        ST_API:      r = ST_AP;
        ST_IS:       r = ST_ISA;
        default:     r = s;
      endcase
    end else begin
      unique case (s)
        ST_U, ST_UA: r = ST_UI;
        ST_A:        r = ST_AI;
        ST_AP:       r = ST_API;
        ST_S:        r = ST_SI;
        ST_SP:       r = ST_SPI;
        ST_IA:       r = ST_I;
        ST_IPA:      r = ST_IP;
        ST_AU:       r = ST_AUI;
        ST_ISA:      r = ST_IS;
        default:     r = s;
      endcase
    end
    return r;
  endfunction

  function automatic code_t stable_next(input code_t s);
    code_t r;
    unique case (s)
      ST_UI, ST_API, ST_SPI: r = ST_I;
      ST_AI, ST_AUI:         r = ST_IU;
      ST_IA, ST_IUA:         r = ST_AU;
      ST_SI:                 r = ST_IS;
      ST_UA, ST_IPA, ST_ISA: r = ST_A;
      default:               r = s;
    endcase
    return r;
  endfunction

  function automatic code_t short_next(input code_t s);
    code_t r;
    unique case (s)
      ST_A, ST_AU, ST_AP: r = ST_S;
      ST_SI:              r = ST_IS;
      ST_SPI:             r = ST_I;
      default:            r = s;
    endcase
    return r;
  endfunction

  function automatic code_t processed_next(input code_t s);
    code_t r;
    unique case (s)
      ST_A, ST_AU:   r = ST_AP;
      ST_AI, ST_AUI: r = ST_API;
      ST_I, ST_IU:   r = ST_IP;
      ST_IA, ST_IUA: r = ST_IPA;
      ST_S:          r = ST_SP;
      ST_SI:         r = ST_SPI;
      ST_IS:         r = ST_IP;
      default:       r = s;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/dbe_next.sv */
// Next-state logic for one poll: edge, stable, short-hold, processed tables.
// Depends on dbe_pkg.
module dbe_next
  import dbe_pkg::*;
(
  input  cfg_t             cfg,
  input  code_t            code,
  input  logic             prev_active,
  input  logic [TimeW-1:0] change_time,
  input  logic             command,
  input  logic             pin_level,
  input  logic [TimeW-1:0] now_ms,
  output step_t            step
);

  logic             act;
  logic             hit;
  logic [TimeW-1:0] t_chg;
  logic [TimeW-1:0] elapsed;
  logic             deb_ok;
  logic             hold_ok;
  code_t            c_edge;
  code_t            c_stab;
  code_t            c_hold;

  always_comb begin
    act     = (pin_level == cfg.active_level);
    hit     = (act != prev_active) || (code == ST_U);
    t_chg   = hit ? now_ms : change_time;
    elapsed = now_ms - t_chg;
    // zero hold time disables the table
    deb_ok  = (cfg.debounce_ms != '0) &&
              (elapsed >= {{(TimeW-HoldW){1'b0}}, cfg.debounce_ms});
    hold_ok = (cfg.short_hold_ms != '0) &&
              (elapsed >= {{(TimeW-HoldW){1'b0}}, cfg.short_hold_ms});
    c_edge  = hit ? edge_next(code, act) : code;
    c_stab  = deb_ok ? stable_next(c_edge) : c_edge;
    c_hold  = hold_ok ? short_next(c_stab) : c_stab;

    step.code        = command ? processed_next(c_hold) : c_hold;
    step.active      = act;
    step.change_hit  = hit;
    step.change_time = t_chg;
  end

endmodule

/* rtl/core/debounced_button_event_fsm.sv */
// Top level of the debounced button event block: input register, state,
// config registers and result register. Depends on dbe_pkg and dbe_next.

// One poll in, one result out. A transfer on the input side lands in an
// input register; from there the button state, last active sense and
// change time are updated through the four transition tables and the result
// is written to the output register. There are two register stages: the
// input register and the result register. A poll can be taken every cycle
// while the result side drains; the state update is one combinational step
// (one 32-bit subtract, two compares, table lookups). Both sides stall
// independently; with out_tready low the input register still fills once.
// The config port is a plain write port and should only be written while no
// poll is in flight. After reset the state is unknown (U), the last sense is
// inactive and the change time zero.
module debounced_button_event_fsm
  import dbe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [39:0]         in_tdata,   // [0] pin_level, [32:1] now_ms, rest zero
  input  logic                in_tuser,   // [0] command
  // result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // [4:0] button_state, [5] is_active
  // config port
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [HoldW-1:0]    cfg_wdata
);

  cfg_t             cfg_r;
  logic             in_valid_r;
  logic             in_cmd_r;
  logic             in_pin_r;
  logic [TimeW-1:0] in_now_r;
  code_t            code_r;
  logic             prev_active_r;
  logic [TimeW-1:0] change_time_r;
  logic             out_valid_r;
  code_t            out_code_r;
  logic             out_act_r;
  step_t            step;
  logic             fire;
  logic             in_xfer;

  // stage advances when the result register is free or being drained
  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;
  assign in_xfer   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_act_r, out_code_r};

  // config registers; index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_level  <= RST_ACTIVE_LEVEL;
      cfg_r.debounce_ms   <= RST_DEBOUNCE_MS;
      cfg_r.short_hold_ms <= RST_SHORT_HOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_LEVEL: cfg_r.active_level  <= cfg_wdata[0];
        REG_DEBOUNCE_MS:  cfg_r.debounce_ms   <= cfg_wdata;
        REG_SHORT_HOLD:   cfg_r.short_hold_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_cmd_r <= in_tuser;
      in_pin_r <= in_tdata[0];
      in_now_r <= in_tdata[32:1];
    end
  end

  dbe_next u_next (
    .cfg         (cfg_r),
    .code        (code_r),
    .prev_active (prev_active_r),
    .change_time (change_time_r),
    .command     (in_cmd_r),
    .pin_level   (in_pin_r),
    .now_ms      (in_now_r),
    .step        (step)
  );

  // button state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r        <= ST_U;
      prev_active_r <= 1'b0;
      change_time_r <= '0;
    end else if (fire) begin
      code_r        <= step.code;
      prev_active_r <= step.active;
      change_time_r <= step.change_time;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_code_r <= step.code;
      out_act_r  <= step.active;
    end
  end

  // state codes stay within the 21 defined states
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_code_r <= ST_ISA))
    else $error("button state code out of range");

  // any processed poll leaves the unknown state
  a_leave_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (code_r != ST_U))
    else $error("state still unknown after a poll");

  // result register mirrors the state just written
  a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (out_code_r == code_r) && (out_act_r == prev_active_r))
    else $error("result does not match updated state");

  // a change always records the poll time
  a_change_time: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && step.change_hit) |=> (change_time_r == $past(in_now_r)))
    else $error("change time not recorded");

endmodule
